### design/modular_exponentiation_unit_assert.svh
// assertion macros used by the exponentiation unit
// all of them sample on the rising edge of clock and stay quiet during reset
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MEU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MEU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mexp_pkg.sv
package mexp_pkg;

   // operand width used by the arithmetic, in bits
   localparam int WIDTH = 64;
   // width of the payload and configuration ports
   localparam int PORT_W = 64;
   // bit counter for one shift-add pass over the multiplier
   localparam int CNT_W = $clog2(WIDTH);
   // configuration register index width and codes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPONENT = CSR_INDEX_W'(1);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_REDUCE,
      ST_BIT,
      ST_MUL,
      ST_SQR,
      ST_RESP
   } state_type;

   // request into the shared modular multiplier
   typedef struct packed {
      logic             start;
      logic [WIDTH-1:0] op_a;
      logic [WIDTH-1:0] op_b;
   } mul_req_type;

   // status back from the shared modular multiplier
   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] product;
   } mul_rsp_type;

endpackage

### design/mexp_mulmod.sv
// shift-add modular multiplier, one multiplier bit per cycle
module mexp_mulmod
   import mexp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mul_req_type       req,
   input  logic [WIDTH-1:0]  modulus,
   output mul_rsp_type       rsp
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH:0]   m2_ff, m2_in;
   logic             zero_ff, zero_in;

   logic [WIDTH-1:0] addend;
   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] diff1;
   logic [WIDTH+1:0] diff2;
   logic [WIDTH-1:0] step;

   // one step: acc = 2*acc + (bit ? a : 0), brought back below the modulus
   always_comb begin
      addend = b_ff[WIDTH-1] ? a_ff : '0;
      sum    = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
      diff1  = sum - {2'b00, m_ff};
      diff2  = sum - {1'b0, m2_ff};
      if (zero_ff) begin
         // no modulus: wrap at the operand width
         step = sum[WIDTH-1:0];
      end else if (sum >= {1'b0, m2_ff}) begin
         step = diff2[WIDTH-1:0];
      end else if (sum >= {2'b00, m_ff}) begin
         step = diff1[WIDTH-1:0];
      end else begin
         step = sum[WIDTH-1:0];
      end
   end

   // load on start, then walk the multiplier from its top bit
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      m2_in   = m2_ff;
      zero_in = zero_ff;
      if (run_ff) begin
         acc_in = step;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         acc_in  = '0;
         a_in    = req.op_a;
         b_in    = req.op_b;
         m_in    = modulus;
         m2_in   = {modulus, 1'b0};
         zero_in = (modulus == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      m2_ff   <= m2_in;
      zero_ff <= zero_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

### design/modular_exponentiation_unit.sv
// modular exponentiation unit: result = message ^ exponent mod modulus
//
// configuration: csr_write with csr_index 0 (modulus) or 1 (exponent) and
// csr_wdata stores a register at the clock edge; other indexes are ignored.
// both registers come out of reset as 1. write them only while busy is low.
// a zero modulus means no reduction: products wrap at the operand width.
// input: a message beat is taken at an edge with start high and busy low.
// busy stays high until the result strobe has gone by.
// output: rsp_valid is high for one cycle with rsp_result_value; the
// receiver cannot stall, so the beat is simply presented once.
// sequence: the message is first reduced by one pass of the shared
// shift-add multiplier, then each exponent bit up to the highest set one
// costs a squaring, or the closing multiply for the top bit, and each
// other set bit a further multiply; a zero exponent goes from the
// reduction straight to the result. busy covers the whole operation,
// the strobe in its last cycle. one item is in flight at a time; the
// multiplier's one bit per cycle sets the rate. reset returns the
// sequencer to idle at once.
`include "modular_exponentiation_unit_assert.svh"

module modular_exponentiation_unit
   import mexp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [PORT_W-1:0]      req_message_value,
   output logic                   rsp_valid,
   output logic [PORT_W-1:0]      rsp_result_value,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PORT_W-1:0]      csr_wdata
);

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] exponent_ff, exponent_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] exp_ff, exp_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // shared modular multiplier
   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .modulus (modulus_ff),
      .rsp     (mul_rsp)
   );

   // configuration register writes
   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_wdata[WIDTH-1:0];
            CSR_EXPONENT: exponent_in = csr_wdata[WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: reduce the base, then scan the exponent from its low bit
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      mul_req.start = 1'b0;
      mul_req.op_a  = base_ff;
      mul_req.op_b  = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               acc_in   = WIDTH'(1);
               base_in  = req_message_value[WIDTH-1:0];
               exp_in   = exponent_ff;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // base mod m as the product 1 * base
            mul_req.start = 1'b1;
            mul_req.op_a  = WIDTH'(1);
            mul_req.op_b  = base_ff;
            state_in      = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (mul_rsp.done) begin
               base_in  = mul_rsp.product;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (exp_ff == '0) begin
               state_in = ST_RESP;
            end else if (exp_ff[0]) begin
               mul_req.start = 1'b1;
               mul_req.op_a  = acc_ff;
               mul_req.op_b  = base_ff;
               state_in      = ST_MUL;
            end else begin
               mul_req.start = 1'b1;
               state_in      = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               if (exp_ff[WIDTH-1:1] == '0) begin
                  // last set bit: the final squaring is not needed
                  exp_in   = '0;
                  state_in = ST_RESP;
               end else begin
                  mul_req.start = 1'b1;
                  state_in      = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mul_rsp.done) begin
               base_in  = mul_rsp.product;
               exp_in   = {1'b0, exp_ff[WIDTH-1:1]};
               state_in = ST_BIT;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         modulus_ff  <= WIDTH'(1);
         exponent_ff <= WIDTH'(1);
      end else begin
         state_ff    <= state_in;
         modulus_ff  <= modulus_in;
         exponent_ff <= exponent_in;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
   end

   // handshake and result beat
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_result_value = PORT_W'(acc_ff);

   // checks on the sequencer
   `MEU_ASSERT_NEXT(a_accept_loads, start && !busy, state_ff == ST_LOAD,
      "accepted beat did not start the base reduction")
   `MEU_ASSERT_NEXT(a_rsp_one_cycle, rsp_valid, !rsp_valid && !busy,
      "result strobe longer than one cycle")
   `MEU_ASSERT_SAME(a_rsp_exp_done, rsp_valid, exp_ff == '0,
      "result issued before the exponent was consumed")
   `MEU_ASSERT_SAME(a_done_expected, mul_rsp.done,
      state_ff == ST_REDUCE || state_ff == ST_MUL || state_ff == ST_SQR,
      "multiplier finished while the sequencer was not waiting")

endmodule
